// ===== sv/hsvrgb_pkg.sv =====
// Shared types, constants and helper functions for the HSV to RGB converter.
package hsvrgb_pkg;

    // Field widths of the stream payloads
    localparam int PIX_W  = 10;
    localparam int HUE_W  = 12;
    localparam int CHAN_W = 8;
    localparam int REM_W  = 6;
    localparam int PROD_W = 16;

    // Payload packing of the input and output tdata words
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Number of register stages in the datapath
    localparam int NUM_STAGES = 5;

    // Arithmetic constants
    localparam logic [HUE_W-1:0]  HUE_FULL    = 12'd360;
    localparam int                SECTOR_DEG  = 60;
    localparam logic [CHAN_W-1:0] FULL_SCALE  = 8'd255;
    localparam int                FRAC_ONE    = 256;
    localparam logic [PROD_W-1:0] ONE_Q       = 16'd65280;   // 255 * 256

    // Sector boundaries in degrees
    localparam logic [HUE_W-1:0] DEG_60  = 12'd60;
    localparam logic [HUE_W-1:0] DEG_120 = 12'd120;
    localparam logic [HUE_W-1:0] DEG_180 = 12'd180;
    localparam logic [HUE_W-1:0] DEG_240 = 12'd240;
    localparam logic [HUE_W-1:0] DEG_300 = 12'd300;

    // Colour wheel sector of the hue
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW,
        SECTOR_YELLOW_GREEN,
        SECTOR_GREEN_CYAN,
        SECTOR_CYAN_BLUE,
        SECTOR_BLUE_MAGENTA,
        SECTOR_MAGENTA_RED
    } sector_t;

    // Fraction table: Q0.8 position within a sector, indexed by degrees into it
    typedef logic [CHAN_W-1:0] frac_lut_t [2**REM_W];

    function automatic frac_lut_t build_frac_lut();
        frac_lut_t lut;
        for (int i = 0; i < 2**REM_W; i++)
        begin
            lut[i] = CHAN_W'((i * FRAC_ONE) / SECTOR_DEG);
        end
        return lut;
    endfunction

    localparam frac_lut_t FRAC_LUT = build_frac_lut();

    // Exact floor(x / 255) for x up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
        return sum[PROD_W-1:CHAN_W];
    endfunction

    // Stage 1: sector found, hue reduced to degrees within the sector
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        logic              show;
    } st1_t;

    // Stage 2: fraction within the sector
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        sector_t           sector;
        logic [CHAN_W-1:0] frac;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        logic              show;
    } st2_t;

    // Stage 3: scale factors for p, q and t
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        sector_t           sector;
        logic [CHAN_W-1:0] p_fac;
        logic [PROD_W-1:0] q_fac;
        logic [PROD_W-1:0] t_fac;
        logic [CHAN_W-1:0] val;
        logic              show;
    } st3_t;

    // Stage 4: products scaled down to a single division by 255
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        sector_t           sector;
        logic [PROD_W-1:0] p_num;
        logic [PROD_W-1:0] q_num;
        logic [PROD_W-1:0] t_num;
        logic [CHAN_W-1:0] val;
        logic              show;
    } st4_t;

    // Stage 5: finished pixel
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              show;
    } st5_t;

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter: five-stage pipeline with stream handshakes.
//
// Input channel (s_axis_*): one pixel per transaction, with hue, saturation,
// brightness and pixel index in tdata and the strip refresh request in tlast.
// Output channel (m_axis_*): one transaction per input pixel, in order, with
// the pixel index and 8-bit red, green and blue in tdata and the refresh
// request copied to tlast.
// Pixels pass through the stage 1 to 5 registers in order; stage 5 feeds
// m_axis. Throughput: one pixel per clock while unstalled, set by the five
// register stages (sector split, fraction lookup, scale factors, brightness
// products, divide and route), each taking a new pixel every unstalled cycle.
// Stalls: every stage holds its contents while the stage after it is full and
// cannot advance; s_axis_tready falls only when the whole pipeline is full and
// m_axis_tready is low. Bubbles are squeezed out while the output waits.
// Reset: rst_n clears all stage valid flags asynchronously; no pixel is lost
// or repeated across a stall, and there is no state between pixels.
module hsv_to_rgb_converter
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] pixel_index, [21:10] hue, [29:22] saturation, [37:30] brightness,
    // [39:38] zero
    input  logic [hsvrgb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                s_axis_tlast,    // show_now

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] pixel_out, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
    output logic [hsvrgb_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast     // show_request
);

    logic [hsvrgb_pkg::NUM_STAGES-1:0] valid_reg;
    logic [hsvrgb_pkg::NUM_STAGES-1:0] valid_next;
    logic [hsvrgb_pkg::NUM_STAGES-1:0] adv;

    hsvrgb_pkg::st1_t st1_reg, st1_next;
    hsvrgb_pkg::st2_t st2_reg, st2_next;
    hsvrgb_pkg::st3_t st3_reg, st3_next;
    hsvrgb_pkg::st4_t st4_reg, st4_next;
    hsvrgb_pkg::st5_t st5_reg, st5_next;

    logic [hsvrgb_pkg::PIX_W-1:0]  in_pix;
    logic [hsvrgb_pkg::HUE_W-1:0]  in_hue;
    logic [hsvrgb_pkg::CHAN_W-1:0] in_sat;
    logic [hsvrgb_pkg::CHAN_W-1:0] in_val;
    logic [hsvrgb_pkg::HUE_W-1:0]  hue_eff;
    logic [hsvrgb_pkg::HUE_W-1:0]  hue_rem;
    logic [8:0]                    frac_comp;
    logic [hsvrgb_pkg::PROD_W:0]   t_prod;
    logic [hsvrgb_pkg::PROD_W-1:0] q_prod;
    logic [23:0]                   q_full;
    logic [23:0]                   t_full;
    logic [hsvrgb_pkg::CHAN_W-1:0] p_res;
    logic [hsvrgb_pkg::CHAN_W-1:0] q_res;
    logic [hsvrgb_pkg::CHAN_W-1:0] t_res;

    logic in_acc;
    logic out_acc;

    // Unpack the input transaction
    assign in_pix = s_axis_tdata[9:0];
    assign in_hue = s_axis_tdata[21:10];
    assign in_sat = s_axis_tdata[29:22];
    assign in_val = s_axis_tdata[37:30];

    // Advance each stage when it is empty or the stage after it advances
    always_comb
    begin
        adv[4] = !valid_reg[4] || m_axis_tready;
        adv[3] = !valid_reg[3] || adv[4];
        adv[2] = !valid_reg[2] || adv[3];
        adv[1] = !valid_reg[1] || adv[2];
        adv[0] = !valid_reg[0] || adv[1];
    end

    assign s_axis_tready = adv[0];
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    // Move valid flags along with the data
    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < hsvrgb_pkg::NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: fold an out-of-range hue to zero and split it into sector and degrees within
    always_comb
    begin
        hue_eff = (in_hue >= hsvrgb_pkg::HUE_FULL) ? '0 : in_hue;
        priority if (hue_eff >= hsvrgb_pkg::DEG_300)
        begin
            st1_next.sector = hsvrgb_pkg::SECTOR_MAGENTA_RED;
            hue_rem         = hue_eff - hsvrgb_pkg::DEG_300;
        end
        else if (hue_eff >= hsvrgb_pkg::DEG_240)
        begin
            st1_next.sector = hsvrgb_pkg::SECTOR_BLUE_MAGENTA;
            hue_rem         = hue_eff - hsvrgb_pkg::DEG_240;
        end
        else if (hue_eff >= hsvrgb_pkg::DEG_180)
        begin
            st1_next.sector = hsvrgb_pkg::SECTOR_CYAN_BLUE;
            hue_rem         = hue_eff - hsvrgb_pkg::DEG_180;
        end
        else if (hue_eff >= hsvrgb_pkg::DEG_120)
        begin
            st1_next.sector = hsvrgb_pkg::SECTOR_GREEN_CYAN;
            hue_rem         = hue_eff - hsvrgb_pkg::DEG_120;
        end
        else if (hue_eff >= hsvrgb_pkg::DEG_60)
        begin
            st1_next.sector = hsvrgb_pkg::SECTOR_YELLOW_GREEN;
            hue_rem         = hue_eff - hsvrgb_pkg::DEG_60;
        end
        else
        begin
            st1_next.sector = hsvrgb_pkg::SECTOR_RED_YELLOW;
            hue_rem         = hue_eff;
        end
        st1_next.pix  = in_pix;
        st1_next.rem  = hue_rem[hsvrgb_pkg::REM_W-1:0];
        st1_next.sat  = in_sat;
        st1_next.val  = in_val;
        st1_next.show = s_axis_tlast;
    end

    // Stage 2: look up the Q0.8 fraction within the sector
    always_comb
    begin
        st2_next.pix    = st1_reg.pix;
        st2_next.sector = st1_reg.sector;
        st2_next.frac   = hsvrgb_pkg::FRAC_LUT[st1_reg.rem];
        st2_next.sat    = st1_reg.sat;
        st2_next.val    = st1_reg.val;
        st2_next.show   = st1_reg.show;
    end

    // Stage 3: form the scale factors of p, q and t
    always_comb
    begin
        frac_comp = 9'(hsvrgb_pkg::FRAC_ONE) - {1'b0, st2_reg.frac};
        q_prod    = 16'(st2_reg.sat) * 16'(st2_reg.frac);
        t_prod    = 17'(st2_reg.sat) * 17'(frac_comp);

        st3_next.pix    = st2_reg.pix;
        st3_next.sector = st2_reg.sector;
        st3_next.p_fac  = hsvrgb_pkg::FULL_SCALE - st2_reg.sat;
        st3_next.q_fac  = hsvrgb_pkg::ONE_Q - q_prod;
        st3_next.t_fac  = hsvrgb_pkg::ONE_Q - t_prod[hsvrgb_pkg::PROD_W-1:0];
        st3_next.val    = st2_reg.val;
        st3_next.show   = st2_reg.show;
    end

    // Stage 4: scale by brightness; drop the low byte of the 255*256 divisor of q and t
    always_comb
    begin
        q_full = 24'(st3_reg.val) * 24'(st3_reg.q_fac);
        t_full = 24'(st3_reg.val) * 24'(st3_reg.t_fac);

        st4_next.pix    = st3_reg.pix;
        st4_next.sector = st3_reg.sector;
        st4_next.p_num  = 16'(st3_reg.val) * 16'(st3_reg.p_fac);
        st4_next.q_num  = q_full[23:8];
        st4_next.t_num  = t_full[23:8];
        st4_next.val    = st3_reg.val;
        st4_next.show   = st3_reg.show;
    end

    // Stage 5: divide by 255 and route the terms by sector
    always_comb
    begin
        p_res = hsvrgb_pkg::div255(st4_reg.p_num);
        q_res = hsvrgb_pkg::div255(st4_reg.q_num);
        t_res = hsvrgb_pkg::div255(st4_reg.t_num);

        st5_next.pix  = st4_reg.pix;
        st5_next.show = st4_reg.show;
        unique case (st4_reg.sector)
            hsvrgb_pkg::SECTOR_RED_YELLOW:
            begin
                st5_next.red   = st4_reg.val;
                st5_next.green = t_res;
                st5_next.blue  = p_res;
            end
            hsvrgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                st5_next.red   = q_res;
                st5_next.green = st4_reg.val;
                st5_next.blue  = p_res;
            end
            hsvrgb_pkg::SECTOR_GREEN_CYAN:
            begin
                st5_next.red   = p_res;
                st5_next.green = st4_reg.val;
                st5_next.blue  = t_res;
            end
            hsvrgb_pkg::SECTOR_CYAN_BLUE:
            begin
                st5_next.red   = p_res;
                st5_next.green = q_res;
                st5_next.blue  = st4_reg.val;
            end
            hsvrgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                st5_next.red   = t_res;
                st5_next.green = p_res;
                st5_next.blue  = st4_reg.val;
            end
            default:
            begin
                st5_next.red   = st4_reg.val;
                st5_next.green = p_res;
                st5_next.blue  = q_res;
            end
        endcase
    end

    // Hold payload while a stage stalls; load it when the stage advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            st1_reg <= st1_next;
        end
        if (adv[1])
        begin
            st2_reg <= st2_next;
        end
        if (adv[2])
        begin
            st3_reg <= st3_next;
        end
        if (adv[3])
        begin
            st4_reg <= st4_next;
        end
        if (adv[4])
        begin
            st5_reg <= st5_next;
        end
    end

    // Pack the output transaction
    assign m_axis_tvalid = valid_reg[4];
    assign m_axis_tlast  = st5_reg.show;
    assign m_axis_tdata  = {6'd0, st5_reg.blue, st5_reg.green, st5_reg.red, st5_reg.pix};

    // A stalled output stage keeps its pixel
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && !m_axis_tready) |=> valid_reg[4])
        else $error("output stage lost a pixel while stalled");

    // With the receiver ready the pipeline never refuses input
    a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled although output is ready");

    // An empty output stage always lets input in
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // Occupancy changes only by accepted and delivered transactions
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) ==
                  $countones($past(valid_reg)) + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline occupancy does not match transactions");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the HSV to RGB pixel converter stream pipeline.
module tb;

    // Arithmetic of the colour conversion
    localparam int unsigned HUE_WRAP    = 360;
    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned CHAN_MAX    = 255;
    localparam int unsigned FRAC_SCALE  = 256;
    localparam int unsigned UNITY_Q     = CHAN_MAX * FRAC_SCALE;

    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_PER_PHASE = 630;

    // One input pixel
    typedef struct packed {
        logic [hsvrgb_pkg::PIX_W-1:0]  pix;
        logic [hsvrgb_pkg::HUE_W-1:0]  hue;
        logic [hsvrgb_pkg::CHAN_W-1:0] sat;
        logic [hsvrgb_pkg::CHAN_W-1:0] val;
        logic                          show;
    } pixel_t;

    // One converted pixel
    typedef struct packed {
        logic [hsvrgb_pkg::PIX_W-1:0]  pix;
        logic [hsvrgb_pkg::CHAN_W-1:0] red;
        logic [hsvrgb_pkg::CHAN_W-1:0] green;
        logic [hsvrgb_pkg::CHAN_W-1:0] blue;
        logic                          show;
    } colour_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [hsvrgb_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [hsvrgb_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    pixel_t      pending_pixels[$];
    colour_t     expected_colours[$];
    pixel_t      pixel_on_bus;
    int unsigned src_idle_pct = 37;
    int unsigned sink_idle_pct = 51;
    int          mismatch_count = 0;
    bit          drain_timeout = 1'b0;

    hsv_to_rgb_converter DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected colour of one pixel
    function automatic colour_t hsv_to_rgb(pixel_t px);
        colour_t             c;
        int unsigned         h;
        int unsigned         s;
        int unsigned         v;
        int unsigned         frac;
        int unsigned         p;
        int unsigned         q;
        int unsigned         t;
        hsvrgb_pkg::sector_t sec;
        c.pix  = px.pix;
        c.show = px.show;
        h = 32'(px.hue);
        s = 32'(px.sat);
        v = 32'(px.val);
        if (s == 0)
        begin
            c.red   = 8'(v);
            c.green = 8'(v);
            c.blue  = 8'(v);
        end
        else
        begin
            // Out-of-range hue folds to zero, no modulo wrap
            if (h >= HUE_WRAP)
                h = 0;
            sec  = hsvrgb_pkg::sector_t'(h / SECTOR_SPAN);
            frac = ((h % SECTOR_SPAN) * FRAC_SCALE) / SECTOR_SPAN;
            p = (v * (CHAN_MAX - s)) / CHAN_MAX;
            q = (v * (UNITY_Q - s * frac)) / UNITY_Q;
            t = (v * (UNITY_Q - s * (FRAC_SCALE - frac))) / UNITY_Q;
            case (sec)
                hsvrgb_pkg::SECTOR_RED_YELLOW:
                begin
                    c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
                end
                hsvrgb_pkg::SECTOR_YELLOW_GREEN:
                begin
                    c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
                end
                hsvrgb_pkg::SECTOR_GREEN_CYAN:
                begin
                    c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
                end
                hsvrgb_pkg::SECTOR_CYAN_BLUE:
                begin
                    c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
                end
                hsvrgb_pkg::SECTOR_BLUE_MAGENTA:
                begin
                    c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
                end
                default:
                begin
                    c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
                end
            endcase
        end
        return c;
    endfunction

    // Random pixel biased towards sector boundaries, gray and extremes
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned pick;
        int unsigned k;
        px.pix  = hsvrgb_pkg::PIX_W'($urandom_range(1023));
        px.show = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 75)
            px.hue = hsvrgb_pkg::HUE_W'($urandom_range(HUE_WRAP - 1));
        else if (pick < 85)
            px.hue = hsvrgb_pkg::HUE_W'($urandom_range(4095, HUE_WRAP));
        else
        begin
            k = $urandom_range(6);
            px.hue = hsvrgb_pkg::HUE_W'(k * SECTOR_SPAN);
            if (k > 0 && $urandom_range(1) == 1)
                px.hue = px.hue - hsvrgb_pkg::HUE_W'(1);
        end
        pick = $urandom_range(99);
        if (pick < 10)
            px.sat = '0;
        else if (pick < 20)
            px.sat = 8'd255;
        else if (pick < 25)
            px.sat = 8'd1;
        else
            px.sat = hsvrgb_pkg::CHAN_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 10)
            px.val = '0;
        else if (pick < 20)
            px.val = 8'd255;
        else
            px.val = hsvrgb_pkg::CHAN_W'($urandom_range(255));
        return px;
    endfunction

    task automatic add_pixel(input int unsigned pix, input int unsigned hue,
                             input int unsigned sat, input int unsigned val,
                             input bit show);
        pixel_t px;
        px.pix  = hsvrgb_pkg::PIX_W'(pix);
        px.hue  = hsvrgb_pkg::HUE_W'(hue);
        px.sat  = hsvrgb_pkg::CHAN_W'(sat);
        px.val  = hsvrgb_pkg::CHAN_W'(val);
        px.show = show;
        pending_pixels.push_back(px);
    endtask

    // Hold until every pixel is sent and every colour has come back
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        while ((pending_pixels.size() != 0 || s_axis_tvalid || expected_colours.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
            drain_timeout = 1'b1;
    endtask

    // Driver: record each accepted transaction, then offer the next pixel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_colours.push_back(hsv_to_rgb(pixel_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    pixel_on_bus = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, pixel_on_bus.val, pixel_on_bus.sat,
                                      pixel_on_bus.hue, pixel_on_bus.pix};
                    s_axis_tlast  <= pixel_on_bus.show;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output transaction, then randomize backpressure
    always @(posedge clk or negedge rst_n)
    begin
        colour_t got;
        colour_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pix   = m_axis_tdata[9:0];
                got.red   = m_axis_tdata[17:10];
                got.green = m_axis_tdata[25:18];
                got.blue  = m_axis_tdata[33:26];
                got.show  = m_axis_tlast;
                if (expected_colours.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected pixel %0d rgb %0d/%0d/%0d show %0b",
                                 got.pix, got.red, got.green, got.blue, got.show);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_colours.pop_front();
                    if (got.pix !== want.pix || got.red !== want.red
                        || got.green !== want.green || got.blue !== want.blue
                        || got.show !== want.show)
                    begin
                        if (mismatch_count < 10)
                            $display({"mismatch: expected pixel %0d rgb %0d/%0d/%0d show %0b,",
                                      " got pixel %0d rgb %0d/%0d/%0d show %0b"},
                                     want.pix, want.red, want.green, want.blue, want.show,
                                     got.pix, got.red, got.green, got.blue, got.show);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Stimulus sequence and end of run
    initial
    begin
        int unsigned k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sector boundaries at full saturation and brightness
        for (k = 0; k < 6; k++)
        begin
            add_pixel(2 * k, k * SECTOR_SPAN, 255, 255, 1'b0);
            add_pixel(2 * k + 1, k * SECTOR_SPAN + 59, 255, 255, 1'b0);
        end
        // Hue folded to zero, gray, dark and near-extreme pixels
        add_pixel(12, 360, 200, 180, 1'b0);
        add_pixel(1023, 4095, 255, 255, 1'b1);
        add_pixel(14, 1000, 128, 200, 1'b0);
        add_pixel(15, 200, 0, 77, 1'b1);
        add_pixel(16, 4095, 0, 255, 1'b0);
        add_pixel(17, 30, 255, 0, 1'b0);
        add_pixel(18, 150, 1, 255, 1'b1);
        add_pixel(19, 210, 255, 1, 1'b0);
        add_pixel(1023, 330, 100, 100, 1'b1);
        add_pixel(0, 45, 255, 128, 1'b1);
        repeat (RANDOM_PER_PHASE - 22) pending_pixels.push_back(random_pixel());
        wait_for_drain();

        // Swap idling between the two sides
        src_idle_pct  = 51;
        sink_idle_pct = 37;
        repeat (RANDOM_PER_PHASE) pending_pixels.push_back(random_pixel());
        wait_for_drain();

        // Full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) pending_pixels.push_back(random_pixel());
        wait_for_drain();
        repeat (hsvrgb_pkg::NUM_STAGES * 4) @(negedge clk);

        if (mismatch_count == 0 && !drain_timeout && expected_colours.size() == 0)
            $display("hsv_to_rgb_converter test passed");
        else
            $display("hsv_to_rgb_converter test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("hsv_to_rgb_converter test failed");
        $finish;
    end

endmodule
